@@ rtl/core/hsr_pkg.sv @@
// ----------------------------------------------------------------------------
// hsr_pkg: shared types and constants of the hashed symbol registry
// Payload structs, operation and status codes, and the control structs that
// pass between the top level, the hash unit and the two table units.
// ----------------------------------------------------------------------------
package hsr_pkg;

  localparam int HashW   = 32;
  localparam int ByteW   = 8;
  localparam int EntryW  = 9;
  localparam int OpW     = 2;
  localparam int StatusW = 2;

  localparam int VarDepthDef  = 256;
  localparam int FuncDepthDef = 256;

  // Operation codes. Code 3 behaves as a lookup.
  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OpW-1:0] OP_CLEAR  = 2'd2;

  // Status codes.
  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_MISS = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;

  // One-at-a-time shift amounts.
  localparam int FoldShl = 10;
  localparam int FoldShr = 6;
  localparam int FinShl1 = 3;
  localparam int FinShr  = 11;
  localparam int FinShl2 = 15;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic             table_sel;
    logic             byte_valid;
    logic [ByteW-1:0] name_byte;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [HashW-1:0]   name_hash;
    logic [EntryW-1:0]  entry_count;
  } out_t;

  // Control from the top level to the hash unit.
  typedef struct packed {
    logic             take;
    logic             byte_valid;
    logic             last;
    logic [ByteW-1:0] name_byte;
    logic             fin1;
    logic             fin2;
  } hash_ctl_t;

  // Command to a table unit.
  typedef struct packed {
    logic             start;
    logic [OpW-1:0]   op;
    logic [HashW-1:0] key;
  } tbl_cmd_t;

  // Completion from a table unit.
  typedef struct packed {
    logic               done;
    logic [StatusW-1:0] status;
    logic [EntryW-1:0]  entry_count;
  } tbl_rsp_t;

endpackage

@@ rtl/core/hashed_symbol_registry_unit.sv @@
// ----------------------------------------------------------------------------
// hashed_symbol_registry_unit: two-table registry keyed by one-at-a-time hashes
// A byte that is not the last of a name is taken while busy stays low.
// After the last byte the unit steps through S_FIN1, S_FIN2, S_CALL and S_WAIT,
// where it waits for the table: a clear needs no scan, a lookup or insert scans
// to a match or the last entry. busy drops with the strobe. No receiver stall.
// Synchronous reset empties both tables and zeroes the running hash; no clearing pass.
// ----------------------------------------------------------------------------
module hashed_symbol_registry_unit
  import hsr_pkg::*;
#(
  parameter int VAR_DEPTH  = VarDepthDef,
  parameter int FUNC_DEPTH = FuncDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIN1 = 5'b00010,
    S_FIN2 = 5'b00100,
    S_CALL = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic             sel_r, sel_nxt;
  logic [OpW-1:0]   op_r, op_nxt;
  logic             accept;
  hash_ctl_t        hctl;
  logic [HashW-1:0] name_hash;
  tbl_cmd_t         var_cmd, func_cmd;
  tbl_rsp_t         var_rsp, func_rsp, sel_rsp;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    hctl.take       = accept;
    hctl.byte_valid = in_data.byte_valid;
    hctl.last       = in_data.last;
    hctl.name_byte  = in_data.name_byte;
    hctl.fin1       = (state_r == S_FIN1);
    hctl.fin2       = (state_r == S_FIN2);
  end

  hsr_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (hctl),
    .name_hash (name_hash)
  );

  always_comb begin
    var_cmd.start  = (state_r == S_CALL) && !sel_r;
    var_cmd.op     = op_r;
    var_cmd.key    = name_hash;
    func_cmd.start = (state_r == S_CALL) && sel_r;
    func_cmd.op    = op_r;
    func_cmd.key   = name_hash;
  end

  hsr_table #(.DEPTH(VAR_DEPTH)) u_var_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (var_cmd),
    .rsp   (var_rsp)
  );

  hsr_table #(.DEPTH(FUNC_DEPTH)) u_func_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (func_cmd),
    .rsp   (func_rsp)
  );

  assign sel_rsp = sel_r ? func_rsp : var_rsp;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    op_nxt        = op_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_data.last) begin
          state_nxt = S_FIN1;
          sel_nxt   = in_data.table_sel;
          op_nxt    = in_data.op;
        end
      end
      S_FIN1: state_nxt = S_FIN2;
      S_FIN2: state_nxt = S_CALL;
      S_CALL: state_nxt = S_WAIT;
      S_WAIT: begin
        if (sel_rsp.done) begin
          state_nxt           = S_IDLE;
          out_valid_nxt       = 1'b1;
          out_nxt.status      = sel_rsp.status;
          out_nxt.name_hash   = name_hash;
          out_nxt.entry_count = sel_rsp.entry_count;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    op_r  <= op_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/hsr_hash.sv @@
// ----------------------------------------------------------------------------
// hsr_hash: one-at-a-time hash unit
// Folds one sign-extended byte per transfer into the running hash and runs
// the final mixing in two steps after the last byte of a name.
// ----------------------------------------------------------------------------
module hsr_hash
  import hsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  hash_ctl_t        ctl,
  output logic [HashW-1:0] name_hash
);

  logic [HashW-1:0] accum_r, accum_nxt;
  logic [HashW-1:0] fin_r, fin_nxt;
  logic [HashW-1:0] ext, h1, h2, h3, folded;
  logic [HashW-1:0] g1, g2, g3;

  always_comb begin
    ext    = {{(HashW-ByteW){ctl.name_byte[ByteW-1]}}, ctl.name_byte};
    h1     = accum_r + ext;
    h2     = h1 + (h1 << FoldShl);
    h3     = h2 ^ (h2 >> FoldShr);
    folded = ctl.byte_valid ? h3 : accum_r;

    g1 = fin_r + (fin_r << FinShl1);
    g2 = g1 ^ (g1 >> FinShr);
    g3 = fin_r + (fin_r << FinShl2);

    accum_nxt = accum_r;
    fin_nxt   = fin_r;
    if (ctl.take) begin
      accum_nxt = ctl.last ? '0 : folded;
      if (ctl.last) begin
        fin_nxt = folded;
      end
    end else if (ctl.fin1) begin
      fin_nxt = g2;
    end else if (ctl.fin2) begin
      fin_nxt = g3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else begin
      accum_r <= accum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
  end

  assign name_hash = fin_r;

endmodule

@@ rtl/core/hsr_table.sv @@
// ----------------------------------------------------------------------------
// hsr_table: one symbol table
// Holds the hashes in a synchronous memory with a fill count. Inserts and
// lookups scan the filled entries one per cycle; a clear skips the scan.
// ----------------------------------------------------------------------------
module hsr_table
  import hsr_pkg::*;
#(
  parameter int DEPTH = VarDepthDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  tbl_cmd_t cmd,
  output tbl_rsp_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_SCAN = 2'b10
  } tstate_t;

  tstate_t          state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [OpW-1:0]   op_r, op_nxt;
  logic [HashW-1:0] key_r, key_nxt;
  logic             rd_vld_r;
  logic [HashW-1:0] rd_data_r;
  logic             issue, match, finish;
  logic             we;
  tbl_rsp_t         rsp_r, rsp_nxt;

  logic [HashW-1:0] mem [DEPTH];

  always_comb begin
    issue  = (state_r == T_SCAN) && (idx_r < count_r);
    match  = rd_vld_r && (rd_data_r == key_r);
    finish = (state_r == T_SCAN) && (match || (!issue && !rd_vld_r));

    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    we        = 1'b0;
    rsp_nxt   = '0;

    unique case (state_r)
      T_IDLE: begin
        if (cmd.start) begin
          if (cmd.op == OP_CLEAR) begin
            count_nxt           = '0;
            rsp_nxt.done        = 1'b1;
            rsp_nxt.status      = ST_OK;
            rsp_nxt.entry_count = '0;
          end else begin
            state_nxt = T_SCAN;
            idx_nxt   = '0;
            op_nxt    = cmd.op;
            key_nxt   = cmd.key;
          end
        end
      end
      T_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (finish) begin
          state_nxt    = T_IDLE;
          rsp_nxt.done = 1'b1;
          if (op_r == OP_INSERT) begin
            if (match) begin
              rsp_nxt.status = ST_MISS;
            end else if (count_r >= DEPTH_C) begin
              rsp_nxt.status = ST_FULL;
            end else begin
              we             = 1'b1;
              count_nxt      = count_r + 1'b1;
              rsp_nxt.status = ST_OK;
            end
          end else begin
            rsp_nxt.status = match ? ST_OK : ST_MISS;
          end
          rsp_nxt.entry_count = EntryW'(count_nxt);
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= T_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
      rsp_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= issue && !finish;
      rsp_r    <= rsp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    op_r  <= op_nxt;
    key_r <= key_nxt;
  end

  // The only write lands at the fill count, past every entry a scan reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[count_r[AW-1:0]] <= key_r;
    end
    if (issue) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  assign rsp = rsp_r;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for hashed_symbol_registry_unit
// Name bytes are sent through the start/busy handshake and folded into a
// one-at-a-time hash by a predictor in the bench, which also keeps its own
// copy of both tables. Every result strobe is compared field by field with
// the oldest predicted result. Directed cases, table overflow and random
// name traffic with idle bursts are run in turn.
// ----------------------------------------------------------------------------
module tb;
  import hsr_pkg::*;

  localparam int VarDepth  = 256;
  localparam int FuncDepth = 256;

  localparam logic [OpW-1:0] OP_LOOKUP_ALT = 2'd3;
  localparam bit VarSel  = 1'b0;
  localparam bit FuncSel = 1'b1;

  localparam int ItemTarget = 1850;
  localparam int StallLimit = 4000;
  localparam int TailCycles = 300;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  hashed_symbol_registry_unit #(
    .VAR_DEPTH (VarDepth),
    .FUNC_DEPTH(FuncDepth)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Predictor state: running hash and the keys held by each table.
  logic [HashW-1:0] name_acc = '0;
  logic [HashW-1:0] var_keys[$];
  logic [HashW-1:0] func_keys[$];
  out_t             pending_results[$];

  // Names already sent, kept so that random traffic hits existing entries.
  bit [95:0]   name_pool[$];
  int unsigned pool_len[$];

  int unsigned items_sent   = 0;
  int unsigned err_count    = 0;
  int unsigned stall_cycles = 0;
  bit          idle_on      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [HashW-1:0] fold_char(logic [HashW-1:0] h, logic [ByteW-1:0] c);
    h = h + {{(HashW - ByteW){c[ByteW-1]}}, c};
    h = h + (h << FoldShl);
    h = h ^ (h >> FoldShr);
    return h;
  endfunction

  function automatic logic [HashW-1:0] finalize_hash(logic [HashW-1:0] h);
    h = h + (h << FinShl1);
    h = h ^ (h >> FinShr);
    h = h + (h << FinShl2);
    return h;
  endfunction

  function automatic in_t make_item(logic [OpW-1:0] op, bit sel, bit valid,
                                    logic [ByteW-1:0] char_v, bit last);
    in_t item;
    item.op         = op;
    item.table_sel  = sel;
    item.byte_valid = valid;
    item.name_byte  = char_v;
    item.last       = last;
    return item;
  endfunction

  // Applies one accepted item to the predicted registry state.
  task automatic predict_registry(input in_t item);
    logic [HashW-1:0] key;
    bit               found;
    int unsigned      cnt;
    int unsigned      depth;
    out_t             res;
    if (item.byte_valid) name_acc = fold_char(name_acc, item.name_byte);
    if (!item.last) return;
    key      = finalize_hash(name_acc);
    name_acc = '0;
    found    = 1'b0;
    if (item.table_sel) begin
      foreach (func_keys[i]) if (func_keys[i] == key) found = 1'b1;
      cnt   = func_keys.size();
      depth = FuncDepth;
    end else begin
      foreach (var_keys[i]) if (var_keys[i] == key) found = 1'b1;
      cnt   = var_keys.size();
      depth = VarDepth;
    end
    case (item.op)
      OP_INSERT: begin
        // The duplicate check wins over the full check.
        if (found) begin
          res.status = ST_MISS;
        end else if (cnt >= depth) begin
          res.status = ST_FULL;
        end else begin
          if (item.table_sel) func_keys.push_back(key);
          else var_keys.push_back(key);
          cnt++;
          res.status = ST_OK;
        end
      end
      OP_CLEAR: begin
        if (item.table_sel) func_keys.delete();
        else var_keys.delete();
        cnt        = 0;
        res.status = ST_OK;
      end
      default: res.status = found ? ST_OK : ST_MISS;
    endcase
    res.name_hash   = key;
    res.entry_count = cnt[EntryW-1:0];
    pending_results.push_back(res);
  endtask

  // Sends one item, with an optional idle burst first. start stays high on
  // return so that back-to-back transfers need no extra edge.
  task automatic send_item(input in_t item);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap   = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) begin
        in_data <= in_t'($urandom);
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    predict_registry(item);
    items_sent++;
  endtask

  // Holds the sender off until every predicted result has arrived.
  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Sends a name of len bytes (chars, lowest byte first) and runs op on it.
  // Noise items with no valid byte may be mixed in, and the operation may
  // ride on a trailing item that carries no byte.
  task automatic send_name(input bit sel, input logic [OpW-1:0] op, input int unsigned len,
                           input bit [95:0] chars, input bit noisy);
    bit trail;
    trail = (len == 0) || (noisy && $urandom_range(0, 7) == 0);
    for (int k = 0; k < int'(len); k++) begin
      if (noisy && $urandom_range(0, 5) == 0)
        send_item(make_item(2'($urandom), 1'($urandom), 1'b0, 8'($urandom), 1'b0));
      if (k == int'(len) - 1 && !trail) begin
        // The final byte carries the operation.
        send_item(make_item(op, sel, 1'b1, chars[8*k +: 8], 1'b1));
      end else begin
        send_item(make_item(2'($urandom), 1'($urandom), 1'b1, chars[8*k +: 8], 1'b0));
      end
    end
    if (trail) send_item(make_item(op, sel, 1'b0, 8'($urandom), 1'b1));
  endtask

  task automatic test_directed_cases();
    // Empty names hash to the finalized value of zero.
    send_name(VarSel, OP_LOOKUP, 0, '0, 1'b0);
    send_name(VarSel, OP_INSERT, 0, '0, 1'b0);
    send_name(VarSel, OP_INSERT, 0, '0, 1'b0);
    // A zero byte is hashed like any other, then found again via a last
    // item that carries no byte.
    send_item(make_item(OP_INSERT, VarSel, 1'b1, 8'h00, 1'b1));
    send_item(make_item(OP_INSERT, VarSel, 1'b1, 8'h00, 1'b0));
    send_item(make_item(OP_LOOKUP, VarSel, 1'b0, 8'hC3, 1'b1));
    // Bytes with the top bit set are sign extended.
    send_item(make_item(OP_INSERT, FuncSel, 1'b1, 8'hFF, 1'b0));
    send_item(make_item(OP_INSERT, FuncSel, 1'b1, 8'h80, 1'b1));
    send_item(make_item(OP_INSERT, FuncSel, 1'b1, 8'h7F, 1'b0));
    send_item(make_item(OP_INSERT, FuncSel, 1'b1, 8'h01, 1'b1));
    send_item(make_item(OP_LOOKUP_ALT, FuncSel, 1'b1, 8'hFF, 1'b0));
    send_item(make_item(OP_LOOKUP_ALT, FuncSel, 1'b1, 8'h80, 1'b1));
    send_item(make_item(OP_LOOKUP, VarSel, 1'b1, 8'hFF, 1'b0));
    send_item(make_item(OP_LOOKUP, VarSel, 1'b1, 8'h80, 1'b1));
    // An invalid byte in the middle of a name leaves the hash alone.
    send_item(make_item(OP_CLEAR, VarSel, 1'b1, 8'h7F, 1'b0));
    send_item(make_item(OP_CLEAR, FuncSel, 1'b0, 8'h55, 1'b0));
    send_item(make_item(OP_LOOKUP, FuncSel, 1'b1, 8'h01, 1'b1));
    // Clears report the hash and an empty table.
    send_item(make_item(OP_CLEAR, VarSel, 1'b1, 8'hAA, 1'b1));
    send_item(make_item(OP_LOOKUP, VarSel, 1'b0, 8'h00, 1'b1));
    send_item(make_item(OP_CLEAR, FuncSel, 1'b1, 8'h3C, 1'b1));
    send_item(make_item(OP_LOOKUP_ALT, FuncSel, 1'b1, 8'hFF, 1'b1));
    wait_all_results();
  endtask

  // Fills each table with every single-byte name, which all hash apart, then
  // checks overflow, duplicate priority and lookups on a full table.
  task automatic test_table_full();
    for (int s = 0; s < 2; s++) begin
      send_name(s[0], OP_CLEAR, 1, 96'h5A, 1'b0);
      for (int b = 0; b < 256; b++) send_name(s[0], OP_INSERT, 1, 96'(b), 1'b0);
      send_name(s[0], OP_INSERT, 2, 96'h0201, 1'b1);
      send_name(s[0], OP_INSERT, 1, 96'h10, 1'b1);
      send_name(s[0], OP_LOOKUP, 1, 96'hFF, 1'b1);
      send_name(s[0], OP_LOOKUP_ALT, 2, 96'h0201, 1'b1);
    end
    // The variable table stays full going into random traffic.
    send_name(FuncSel, OP_CLEAR, 0, '0, 1'b0);
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    bit [95:0]      chars;
    int unsigned    len;
    int unsigned    pick;
    int unsigned    r;
    int unsigned    names_done;
    logic [OpW-1:0] op;
    names_done = 0;
    while (items_sent < ItemTarget) begin
      if (names_done % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (items_sent + 200 > ItemTarget) idle_on = 1'b0;
      if (names_done == 150) wait_all_results();
      if (name_pool.size() != 0 && $urandom_range(0, 9) < 3) begin
        pick  = $urandom_range(0, name_pool.size() - 1);
        chars = name_pool[pick];
        len   = pool_len[pick];
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) len = 0;
        else if (r < 14) len = $urandom_range(5, 12);
        else len = $urandom_range(1, 4);
        chars = '0;
        for (int k = 0; k < len; k++)
          chars[8*k +: 8] = $urandom_range(0, 1) ? 8'h61 + 8'($urandom_range(0, 25))
                                                  : 8'($urandom);
        if (name_pool.size() < 64) begin
          name_pool.push_back(chars);
          pool_len.push_back(len);
        end else begin
          pick            = $urandom_range(0, 63);
          name_pool[pick] = chars;
          pool_len[pick]  = len;
        end
      end
      r = $urandom_range(0, 99);
      if (r < 48) op = OP_INSERT;
      else if (r < 78) op = OP_LOOKUP;
      else if (r < 98) op = OP_LOOKUP_ALT;
      else op = OP_CLEAR;
      send_name(1'($urandom), op, len, chars, 1'b1);
      names_done++;
    end
  endtask

  // Compares every result strobe with the oldest prediction.
  initial begin
    out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t ERROR: unexpected result: expected none, actual %h", $time, out_data);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t ERROR: status expected %0d actual %0d",
                     $time, want.status, out_data.status);
            err_count++;
          end
          if (out_data.name_hash !== want.name_hash) begin
            $display("%0t ERROR: name_hash expected %h actual %h",
                     $time, want.name_hash, out_data.name_hash);
            err_count++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $display("%0t ERROR: entry_count expected %0d actual %0d",
                     $time, want.entry_count, out_data.entry_count);
            err_count++;
          end
        end
      end
    end
  end

  // Ends the run when neither an input nor a result transfer happens for
  // too long.
  initial begin
    while (stall_cycles < StallLimit) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t ERROR: no transfer for %0d cycles", $time, StallLimit);
    $display("** hashed_symbol_registry_unit: FAILED **");
    $finish;
  end

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_table_full();
    test_random_traffic();
    wait_all_results();
    repeat (TailCycles) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("** hashed_symbol_registry_unit: PASSED **");
    end else begin
      $display("%0t ERROR: %0d mismatches, %0d results missing",
               $time, err_count, pending_results.size());
      $display("** hashed_symbol_registry_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/hsr_pkg.sv
rtl/core/hsr_hash.sv
rtl/core/hsr_table.sv
rtl/core/hashed_symbol_registry_unit.sv
verif/tb.sv
